// ----- rtl/core/cpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpsc_pkg: shared constants for the consecutive prime sum counter
// Fixed field widths of the query and result transactions and the count ceiling.
// ----------------------------------------------------------------------------
package cpsc_pkg;

  localparam int QUERY_W = 14;
  localparam int COUNT_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

endpackage

// ----- rtl/core/cpsc_query_if.sv -----
// ----------------------------------------------------------------------------
// cpsc_query_if: query channel
// Valid/ready channel carrying one query value per transaction.
// ----------------------------------------------------------------------------
interface cpsc_query_if import cpsc_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [QUERY_W-1:0] query_value;

  modport source (output valid, output query_value, input ready);
  modport sink (input valid, input query_value, output ready);

endinterface

// ----- rtl/core/cpsc_result_if.sv -----
// ----------------------------------------------------------------------------
// cpsc_result_if: result channel
// Valid/ready channel carrying one way count per transaction.
// ----------------------------------------------------------------------------
interface cpsc_result_if import cpsc_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] way_count;

  modport source (output valid, output way_count, input ready);
  modport sink (input valid, input way_count, output ready);

endinterface

// ----- rtl/core/cpsc_sieve.sv -----
// ----------------------------------------------------------------------------
// cpsc_sieve: prime table builder
// Clears the composite flag memory, then runs a sieve of Eratosthenes over it
// and streams the primes found, in ascending order, into the prime list while it has room.
// ----------------------------------------------------------------------------
module cpsc_sieve import cpsc_pkg::*; #(
  parameter int MAX_QUERY   = 16384,
  parameter int PRIME_SLOTS = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  output logic                                  done_o,
  output logic [$clog2(PRIME_SLOTS+1)-1:0]      prime_total_o,
  output logic                                  list_we_o,
  output logic [$clog2(PRIME_SLOTS)-1:0]        list_waddr_o,
  output logic [$clog2(2*MAX_QUERY)-1:0]        list_wdata_o
);

  localparam int SIEVE_SIZE = 2 * MAX_QUERY;
  localparam int PRIME_W    = $clog2(SIEVE_SIZE);
  localparam int NUM_W      = PRIME_W + 1;
  localparam int CNT_W      = $clog2(PRIME_SLOTS + 1);
  localparam int IDX_W      = $clog2(PRIME_SLOTS);

  typedef enum logic [2:0] {
    SV_CLEAR,
    SV_READ,
    SV_TEST,
    SV_MARK,
    SV_DONE
  } sv_state_e;

  sv_state_e        state_q, state_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] mult_q, mult_d;
  logic [CNT_W-1:0] total_q, total_d;

  logic             flag_mem [SIEVE_SIZE];
  logic             flag_rd_q;
  logic             flag_we;
  logic             flag_wdata;

  always_comb begin
    state_d    = state_q;
    num_d      = num_q;
    mult_d     = mult_q;
    total_d    = total_q;
    flag_we    = 1'b0;
    flag_wdata = 1'b0;
    list_we_o  = 1'b0;
    case (state_q)
      SV_CLEAR: begin
        flag_we = 1'b1;
        if (mult_q == NUM_W'(SIEVE_SIZE - 1)) begin
          num_d   = NUM_W'(2);
          state_d = SV_READ;
        end else begin
          mult_d = mult_q + 1'b1;
        end
      end
      SV_READ: begin
        if (num_q >= NUM_W'(SIEVE_SIZE)) begin
          state_d = SV_DONE;
        end else begin
          state_d = SV_TEST;
        end
      end
      SV_TEST: begin
        if (flag_rd_q) begin
          num_d   = num_q + 1'b1;
          state_d = SV_READ;
        end else begin
          // a prime: append while the list has room, then strike its multiples
          if (total_q < CNT_W'(PRIME_SLOTS)) begin
            list_we_o = 1'b1;
            total_d   = total_q + 1'b1;
          end
          mult_d  = num_q + num_q;
          state_d = SV_MARK;
        end
      end
      SV_MARK: begin
        if (mult_q >= NUM_W'(SIEVE_SIZE)) begin
          num_d   = num_q + 1'b1;
          state_d = SV_READ;
        end else begin
          flag_we    = 1'b1;
          flag_wdata = 1'b1;
          mult_d     = mult_q + num_q;
        end
      end
      SV_DONE: begin
      end
      default: begin
        state_d = SV_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SV_CLEAR;
      num_q   <= '0;
      mult_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      num_q   <= num_d;
      mult_q  <= mult_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[mult_q[PRIME_W-1:0]] <= flag_wdata;
    end
    flag_rd_q <= flag_mem[num_q[PRIME_W-1:0]];
  end

  assign done_o        = (state_q == SV_DONE);
  assign prime_total_o = total_q;
  assign list_waddr_o  = total_q[IDX_W-1:0];
  assign list_wdata_o  = num_q[PRIME_W-1:0];

endmodule

// ----- rtl/core/cpsc_walk.sv -----
// ----------------------------------------------------------------------------
// cpsc_walk: two-pointer walk over the prime list
// Holds the prime list memory and, per query, slides a window of consecutive
// primes along it, counting the windows whose sum equals the query.
// ----------------------------------------------------------------------------
module cpsc_walk import cpsc_pkg::*; #(
  parameter int MAX_QUERY   = 16384,
  parameter int PRIME_SLOTS = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  list_we_i,
  input  logic [$clog2(PRIME_SLOTS)-1:0]        list_waddr_i,
  input  logic [$clog2(2*MAX_QUERY)-1:0]        list_wdata_i,
  input  logic [$clog2(PRIME_SLOTS+1)-1:0]      prime_total_i,
  input  logic                                  start_i,
  input  logic [QUERY_W-1:0]                    query_i,
  output logic                                  idle_o,
  output logic                                  res_valid_o,
  output logic [COUNT_W-1:0]                    res_count_o,
  input  logic                                  res_ready_i
);

  localparam int PRIME_W = $clog2(2 * MAX_QUERY);
  localparam int CNT_W   = $clog2(PRIME_SLOTS + 1);
  localparam int IDX_W   = $clog2(PRIME_SLOTS);
  localparam int SUM_W   = ((PRIME_W > QUERY_W) ? PRIME_W : QUERY_W) + 1;

  typedef enum logic [1:0] {
    WK_IDLE,
    WK_WALK,
    WK_DONE
  } wk_state_e;

  wk_state_e          state_q, state_d;
  logic [QUERY_W-1:0] n_q, n_d;
  logic [CNT_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   tail_q, tail_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               res_valid_q, res_valid_d;
  logic [COUNT_W-1:0] res_count_q, res_count_d;

  logic [PRIME_W-1:0] list_mem [PRIME_SLOTS];
  logic [PRIME_W-1:0] head_prime_q;
  logic [PRIME_W-1:0] tail_prime_q;

  logic [SUM_W-1:0]   head_prime;
  logic [SUM_W-1:0]   tail_prime;
  logic [SUM_W-1:0]   target;

  assign head_prime = SUM_W'(head_prime_q);
  assign tail_prime = SUM_W'(tail_prime_q);
  assign target     = SUM_W'(n_q);

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    head_d      = head_q;
    tail_d      = tail_q;
    sum_d       = sum_q;
    count_d     = count_q;
    res_valid_d = res_valid_q;
    res_count_d = res_count_q;
    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      WK_IDLE: begin
        if (start_i) begin
          n_d     = query_i;
          head_d  = '0;
          tail_d  = '0;
          sum_d   = '0;
          count_d = '0;
          state_d = WK_WALK;
        end
      end
      WK_WALK: begin
        if (head_q >= prime_total_i || head_prime > target) begin
          state_d = WK_DONE;
        end else if (sum_q < target && tail_q < prime_total_i) begin
          // grow the window by one prime
          sum_d  = sum_q + tail_prime;
          tail_d = tail_q + 1'b1;
        end else begin
          if (sum_q == target && count_q != COUNT_MAX) begin
            count_d = count_q + 1'b1;
          end
          head_d = head_q + 1'b1;
          if (tail_q > head_q) begin
            sum_d = sum_q - head_prime;
          end else begin
            tail_d = head_q + 1'b1;
            sum_d  = '0;
          end
        end
      end
      WK_DONE: begin
        // hold the count until the result register is free
        if (!res_valid_q || res_ready_i) begin
          res_valid_d = 1'b1;
          res_count_d = count_q;
          state_d     = WK_IDLE;
        end
      end
      default: begin
        state_d = WK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WK_IDLE;
      n_q         <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      res_count_q <= '0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      res_count_q <= res_count_d;
    end
  end

  // read both window ends for the next cycle
  always_ff @(posedge clk_i) begin
    if (list_we_i) begin
      list_mem[list_waddr_i] <= list_wdata_i;
    end
    head_prime_q <= list_mem[head_d[IDX_W-1:0]];
    tail_prime_q <= list_mem[tail_d[IDX_W-1:0]];
  end

  assign idle_o      = (state_q == WK_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_count_o = res_count_q;

endmodule

// ----- rtl/core/consecutive_prime_sum_counter.sv -----
// ----------------------------------------------------------------------------
// consecutive_prime_sum_counter: counts runs of consecutive primes summing to n
//
// Query channel (query_i): one 14-bit value n per transaction. Result channel
// (result_o): one 4-bit way_count per query, the number of runs of one or more
// consecutive primes whose sum is exactly n, saturating at 15.
// After reset the block clears its composite flag memory and sieves it,
// writing each prime into the prime list; query_i.ready stays low until this
// is over. A query walks the prime window one step at a time, reading both
// window ends from the single prime list memory each cycle.
// Queries are handled one at a time. The result sits in an output register, so
// the next query is accepted while a result waits; if the receiver stalls, a
// finished count is held inside until the register empties.
// ----------------------------------------------------------------------------
module consecutive_prime_sum_counter import cpsc_pkg::*; #(
  parameter int MAX_QUERY   = 16384,
  parameter int PRIME_SLOTS = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cpsc_query_if.sink     query_i,
  cpsc_result_if.source  result_o
);

  localparam int PRIME_W = $clog2(2 * MAX_QUERY);
  localparam int CNT_W   = $clog2(PRIME_SLOTS + 1);
  localparam int IDX_W   = $clog2(PRIME_SLOTS);

  logic               sieve_done;
  logic [CNT_W-1:0]   prime_total;
  logic               list_we;
  logic [IDX_W-1:0]   list_waddr;
  logic [PRIME_W-1:0] list_wdata;
  logic               walk_idle;
  logic               query_take;

  cpsc_sieve #(
    .MAX_QUERY   (MAX_QUERY),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_sieve (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .done_o        (sieve_done),
    .prime_total_o (prime_total),
    .list_we_o     (list_we),
    .list_waddr_o  (list_waddr),
    .list_wdata_o  (list_wdata)
  );

  assign query_i.ready = sieve_done && walk_idle;
  assign query_take    = query_i.valid && query_i.ready;

  cpsc_walk #(
    .MAX_QUERY   (MAX_QUERY),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .list_we_i     (list_we),
    .list_waddr_i  (list_waddr),
    .list_wdata_i  (list_wdata),
    .prime_total_i (prime_total),
    .start_i       (query_take),
    .query_i       (query_i.query_value),
    .idle_o        (walk_idle),
    .res_valid_o   (result_o.valid),
    .res_count_o   (result_o.way_count),
    .res_ready_i   (result_o.ready)
  );

  // the prime table, once built, stays built
  assert property (@(posedge clk_i) disable iff (!rst_ni) sieve_done |=> sieve_done)
    else $error("sieve left its done state");

  // no list writes once queries may read it
  assert property (@(posedge clk_i) disable iff (!rst_ni) sieve_done |-> !list_we)
    else $error("prime list written after the sieve finished");

  // one query at a time: a taken query closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) query_take |=> !query_i.ready)
    else $error("query accepted while the walk was busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      prime_total <= CNT_W'(PRIME_SLOTS))
    else $error("prime count beyond list depth");

endmodule
